// ===== design/pcpf_pkg.sv =====
// Shared types and constants for the photon coincidence pair finder.
// Used by every module of the block but pcpf_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pcpf_pkg;

  // Ring of recent hits and the significant bits of a stored timestamp.
  localparam int RING_DEPTH = 16;
  localparam int TIME_BITS  = 48;

  // Fixed field widths of the interface.
  localparam int TIME_W     = 48;
  localparam int REGION_W   = 10;
  localparam int TAG_W      = 16;
  localparam int WINDOW_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam int RING_IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int HIT_Q_DEPTH = 4;
  localparam int HIT_Q_PTR_W = $clog2(HIT_Q_DEPTH);

  // Timestamps keep only TIME_BITS bits when that is below the port width.
  localparam logic [TIME_W-1:0] TIME_MASK =
    (TIME_BITS >= TIME_W) ? {TIME_W{1'b1}} : TIME_W'((64'd1 << TIME_BITS) - 64'd1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_END   = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET      = 24'd3000;
  localparam logic [TIME_W-1:0]   FRAME_START_RESET = '0;
  localparam logic [TIME_W-1:0]   FRAME_END_RESET   = {TIME_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0]   hit_time;
    logic [REGION_W-1:0] hit_region;
    logic [TAG_W-1:0]    hit_tag;
  } hit_t;

  localparam int HIT_W = $bits(hit_t);

  typedef struct packed {
    hit_t first;
    hit_t second;
    logic last;
  } pair_t;

  typedef struct packed {
    logic [WINDOW_W-1:0] window;
    logic [TIME_W-1:0]   frame_start;
    logic [TIME_W-1:0]   frame_end;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pend_valid;
  } scan_status_t;

endpackage

`default_nettype wire

// ===== design/pcpf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the ring of stored hits.
`timescale 1ns / 1ps
`default_nettype none

module pcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/pcpf_hit_queue.sv =====
// Front end: accepts hit requests, trims timestamps and queues them.
// Depends on pcpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcpf_hit_queue
  import pcpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire hit_t in_hit,
  input  wire logic pop,
  output hit_t      head,
  output logic      head_valid
);

  hit_t                 q_r [HIT_Q_DEPTH];
  logic [HIT_Q_PTR_W:0] wr_ptr_r;
  logic [HIT_Q_PTR_W:0] rd_ptr_r;
  logic                 full;
  logic                 empty;
  logic                 push;
  hit_t                 trimmed;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[HIT_Q_PTR_W] != rd_ptr_r[HIT_Q_PTR_W]) &&
                 (wr_ptr_r[HIT_Q_PTR_W-1:0] == rd_ptr_r[HIT_Q_PTR_W-1:0]);

  assign in_stall   = full;
  assign push       = in_valid && !full;
  assign head_valid = !empty;
  assign head       = q_r[rd_ptr_r[HIT_Q_PTR_W-1:0]];

  always_comb begin
    trimmed          = in_hit;
    trimmed.hit_time = in_hit.hit_time & TIME_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r[HIT_Q_PTR_W-1:0]] <= trimmed;
    end
  end

endmodule

`default_nettype wire

// ===== design/pcpf_scanner.sv =====
// Back end: scans the ring of stored hits for each queued hit, emits pairs
// and writes the hit into the ring. Depends on pcpf_pkg and pcpf_ram.
`timescale 1ns / 1ps
`default_nettype none

module pcpf_scanner
  import pcpf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire hit_t   head,
  input  wire logic   head_valid,
  output logic        pop,
  input  wire cfg_t   cfg,
  output logic        out_valid,
  input  wire logic   out_stall,
  output pair_t       out_pair,
  output scan_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } scan_state_t;

  localparam logic [RING_IDX_W:0]   DEPTH_L = (RING_IDX_W + 1)'(RING_DEPTH);
  localparam logic [RING_IDX_W-1:0] LAST_K  = RING_IDX_W'(RING_DEPTH - 1);

  scan_state_t            state_r;
  scan_state_t            state_nxt;
  hit_t                   cur_r;
  logic [RING_IDX_W-1:0]  k_r;
  logic [RING_IDX_W-1:0]  wp_r;
  logic [RING_DEPTH-1:0]  valid_r;
  logic                   s1_v_r;
  logic                   s2_v_r;
  logic                   s2_same_r;
  logic                   s2_first_r;
  logic [TIME_W-1:0]      s2_diff_r;
  hit_t                   s2_hit_r;
  logic                   pend_v_r;
  pair_t                  pend_r;
  logic                   out_v_r;
  pair_t                  out_r;

  logic [RING_IDX_W:0]    idx_sum;
  logic [RING_IDX_W:0]    idx_wrap;
  logic [RING_IDX_W-1:0]  rd_idx;
  logic [HIT_W-1:0]       rd_word;
  hit_t                   rd_hit;
  logic [TIME_W:0]        sub_st;
  logic [TIME_W:0]        sub_ts;
  logic [TIME_W-1:0]      abs_diff;
  logic [TIME_W-1:0]      s2_ft;
  logic                   s2_match;
  logic                   issue;
  logic                   en;
  logic                   out_free;
  logic                   commit_go;
  logic                   load_mid;
  logic                   load_last;
  pair_t                  new_pair;

  // Entry k of the scan sits k places after the write pointer: oldest first.
  assign idx_sum  = {1'b0, wp_r} + {1'b0, k_r};
  assign idx_wrap = (idx_sum >= DEPTH_L) ? (idx_sum - DEPTH_L) : idx_sum;
  assign rd_idx   = idx_wrap[RING_IDX_W-1:0];

  assign issue = (state_r == ST_SCAN);
  assign pop   = (state_r == ST_IDLE) && head_valid;

  pcpf_ram #(
    .WIDTH (HIT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (commit_go),
    .wr_addr (wp_r),
    .wr_data (cur_r),
    .rd_en   (en),
    .rd_addr (rd_idx),
    .rd_data (rd_word)
  );

  assign rd_hit = hit_t'(rd_word);

  // Absolute time difference, taken from whichever subtraction does not borrow.
  assign sub_st   = {1'b0, rd_hit.hit_time} - {1'b0, cur_r.hit_time};
  assign sub_ts   = {1'b0, cur_r.hit_time} - {1'b0, rd_hit.hit_time};
  assign abs_diff = sub_st[TIME_W] ? sub_ts[TIME_W-1:0] : sub_st[TIME_W-1:0];

  assign s2_ft    = s2_first_r ? s2_hit_r.hit_time : cur_r.hit_time;
  assign s2_match = s2_v_r && !s2_same_r &&
                    (s2_diff_r <= TIME_W'(cfg.window)) &&
                    (s2_ft >= cfg.frame_start) && (s2_ft < cfg.frame_end);

  always_comb begin
    new_pair.first  = s2_first_r ? s2_hit_r : cur_r;
    new_pair.second = s2_first_r ? cur_r : s2_hit_r;
    new_pair.last   = 1'b0;
  end

  // A pair is held back one match so that the final one can be flagged; the
  // scan pipeline halts only when that held pair has nowhere to go.
  assign out_free  = !out_v_r || !out_stall;
  assign en        = !(s2_match && pend_v_r && !out_free);
  assign commit_go = (state_r == ST_COMMIT) && (!pend_v_r || out_free);
  assign load_mid  = en && s2_match && pend_v_r;
  assign load_last = commit_go && pend_v_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (en && (k_r == LAST_K)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      wp_r     <= '0;
      valid_r  <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        k_r <= '0;
      end else if (issue && en) begin
        k_r <= k_r + 1'b1;
      end
      if (en) begin
        s1_v_r <= issue && valid_r[rd_idx];
        s2_v_r <= s1_v_r;
      end
      if (en && s2_match) begin
        pend_v_r <= 1'b1;
      end else if (commit_go) begin
        pend_v_r <= 1'b0;
      end
      if (load_mid || load_last) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (commit_go) begin
        valid_r[wp_r] <= 1'b1;
        wp_r          <= (wp_r == LAST_K) ? '0 : (wp_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (en) begin
      s2_same_r  <= (rd_hit.hit_region == cur_r.hit_region);
      s2_first_r <= (rd_hit.hit_region > cur_r.hit_region);
      s2_diff_r  <= abs_diff;
      s2_hit_r   <= rd_hit;
    end
    if (en && s2_match) begin
      pend_r <= new_pair;
    end
    if (load_mid || load_last) begin
      out_r.first  <= pend_r.first;
      out_r.second <= pend_r.second;
      out_r.last   <= load_last;
    end
  end

  assign out_valid         = out_v_r;
  assign out_pair          = out_r;
  assign status.busy       = (state_r != ST_IDLE);
  assign status.pend_valid = pend_v_r;

endmodule

`default_nettype wire

// ===== design/photon_coincidence_pair_finder.sv =====
// Top level of the photon coincidence pair finder: configuration registers,
// hit queue and ring scanner. Depends on pcpf_pkg, pcpf_hit_queue, pcpf_scanner.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted hit is matched against the last RING_DEPTH hits (oldest first)
// and produces one output request per coincident pair, the final one marked
// with out_last_pair; the hit then replaces the oldest ring entry. The scanner
// reads one ring entry per cycle from a memory with a registered read port,
// unless a held pair is blocked by an output stall, and takes no new hit until
// the current one is written into the ring. A four-deep hit queue takes input
// requests while the scanner is busy. Configuration is always ready and must
// be written only while no hit is in flight.
module photon_coincidence_pair_finder
  import pcpf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TIME_W-1:0]     in_hit_time,
  input  wire logic [REGION_W-1:0]   in_hit_region,
  input  wire logic [TAG_W-1:0]      in_hit_tag,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [TIME_W-1:0]          out_first_time,
  output logic [REGION_W-1:0]        out_first_region,
  output logic [TAG_W-1:0]           out_first_tag,
  output logic [TIME_W-1:0]          out_second_time,
  output logic [REGION_W-1:0]        out_second_region,
  output logic [TAG_W-1:0]           out_second_tag,
  output logic                       out_last_pair,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t         cfg_r;
  hit_t         in_hit;
  hit_t         head;
  logic         head_valid;
  logic         pop;
  pair_t        out_pair;
  scan_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window      <= WINDOW_RESET;
      cfg_r.frame_start <= FRAME_START_RESET;
      cfg_r.frame_end   <= FRAME_END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW:      cfg_r.window      <= cfg_data[WINDOW_W-1:0];
        REG_FRAME_START: cfg_r.frame_start <= cfg_data[TIME_W-1:0];
        REG_FRAME_END:   cfg_r.frame_end   <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_hit.hit_time   = in_hit_time;
  assign in_hit.hit_region = in_hit_region;
  assign in_hit.hit_tag    = in_hit_tag;

  pcpf_hit_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_hit     (in_hit),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  pcpf_scanner u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pair   (out_pair),
    .status     (status)
  );

  assign out_first_time    = out_pair.first.hit_time;
  assign out_first_region  = out_pair.first.hit_region;
  assign out_first_tag     = out_pair.first.hit_tag;
  assign out_second_time   = out_pair.second.hit_time;
  assign out_second_region = out_pair.second.hit_region;
  assign out_second_tag    = out_pair.second.hit_tag;
  assign out_last_pair     = out_pair.last;

  // No pair may be left behind once the scanner returns to idle.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !status.busy |-> !status.pend_valid)
    else $error("pending pair held while scanner idle");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_window_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == REG_WINDOW)) |=>
      (cfg_r.window == $past(cfg_data[WINDOW_W-1:0])))
    else $error("window register not updated by write");

endmodule

`default_nettype wire

// ===== tb/tb_photon_coincidence_pair_finder.sv =====
// Self-checking testbench for photon_coincidence_pair_finder: directed hit table, then
// random hit streams under several window and frame settings and idling mixes.
// Depends on pcpf_pkg and the photon_coincidence_pair_finder RTL only.
`timescale 1ns / 1ps

module tb_photon_coincidence_pair_finder
  import pcpf_pkg::*;
();

  localparam int LIMIT_CYCLES = 400000;
  // A hit that finds no partner leaves no trace at the output, so before touching
  // the registers we allow for a full hit queue plus the one being scanned.
  localparam int SETTLE_CYCLES = 8 * (RING_DEPTH + 5);
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_HITS = 25;
  localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_CFG, ROW_HIT, ROW_HIT_NONE, ROW_HIT_ONE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    hit_t                  hit;
    pair_t                 want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_hit_time;
  logic [REGION_W-1:0]   in_hit_region;
  logic [TAG_W-1:0]      in_hit_tag;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TIME_W-1:0]     out_first_time;
  logic [REGION_W-1:0]   out_first_region;
  logic [TAG_W-1:0]      out_first_tag;
  logic [TIME_W-1:0]     out_second_time;
  logic [REGION_W-1:0]   out_second_region;
  logic [TAG_W-1:0]      out_second_tag;
  logic                  out_last_pair;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  photon_coincidence_pair_finder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_hit_time       (in_hit_time),
    .in_hit_region     (in_hit_region),
    .in_hit_tag        (in_hit_tag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_first_time    (out_first_time),
    .out_first_region  (out_first_region),
    .out_first_tag     (out_first_tag),
    .out_second_time   (out_second_time),
    .out_second_region (out_second_region),
    .out_second_tag    (out_second_tag),
    .out_last_pair     (out_last_pair),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Own copy of the ring and the registers.
  hit_t                  ring [RING_DEPTH];
  bit                    ring_filled [RING_DEPTH];
  logic [RING_IDX_W-1:0] ring_wr = '0;
  logic [WINDOW_W-1:0]   cur_window = WINDOW_RESET;
  logic [TIME_W-1:0]     frame_open = FRAME_START_RESET;
  logic [TIME_W-1:0]     frame_close = FRAME_END_RESET;

  pair_t fresh_pairs [$];
  pair_t pending_pairs [$];
  row_t  hit_plan [$];

  logic [TIME_W-1:0] cur_time = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int pairs_seen = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WINDOW:      cur_window = data[WINDOW_W-1:0];
      REG_FRAME_START: frame_open = data[TIME_W-1:0];
      REG_FRAME_END:   frame_close = data[TIME_W-1:0];
      default: ;  // Indexes past the register list change nothing.
    endcase
  endfunction

  // Scans the ring oldest first, collects the coincident pairs in fresh_pairs and
  // then stores the arrival over the oldest entry.
  function automatic void find_coincidences(input hit_t arrival);
    hit_t                  h;
    hit_t                  held;
    logic [TIME_W-1:0]     spread;
    logic [TIME_W-1:0]     lead_time;
    logic                  held_first;
    logic [RING_IDX_W-1:0] idx;
    pair_t                 p;
    h = arrival;
    h.hit_time = arrival.hit_time & TIME_MASK;
    fresh_pairs.delete();
    for (int k = 0; k < RING_DEPTH; k++) begin
      idx = RING_IDX_W'((32'(ring_wr) + k) % RING_DEPTH);
      held = ring[idx];
      if (!ring_filled[idx] || held.hit_region == h.hit_region) continue;
      spread = (held.hit_time > h.hit_time) ? held.hit_time - h.hit_time
                                            : h.hit_time - held.hit_time;
      if (spread > TIME_W'(cur_window)) continue;
      held_first = held.hit_region > h.hit_region;
      lead_time = held_first ? held.hit_time : h.hit_time;
      if (lead_time < frame_open || lead_time >= frame_close) continue;
      p.first = held_first ? held : h;
      p.second = held_first ? h : held;
      p.last = 1'b0;
      fresh_pairs.push_back(p);
    end
    if (fresh_pairs.size() > 0) fresh_pairs[fresh_pairs.size() - 1].last = 1'b1;
    ring[ring_wr] = h;
    ring_filled[ring_wr] = 1'b1;
    ring_wr = RING_IDX_W'((32'(ring_wr) + 1) % RING_DEPTH);
  endfunction

  // Mostly a time-ordered stream whose steps are small against the window, with
  // a few wide steps, steps backwards and jumps thrown in.
  function automatic hit_t next_hit();
    hit_t        h;
    int          pick;
    int unsigned w32;
    w32 = 32'(cur_window);
    pick = $urandom_range(0, 99);
    if (pick < 80) cur_time += TIME_W'($urandom_range(0, w32 / 4));
    else if (pick < 95) cur_time += TIME_W'($urandom_range(0, 2 * w32 + 2));
    else if (pick < 98) cur_time -= TIME_W'($urandom_range(0, w32));
    else cur_time = TIME_W'({$urandom, $urandom});
    h.hit_time = cur_time;
    h.hit_region = ($urandom_range(0, 99) < 70) ? REGION_W'($urandom_range(0, 7))
                                                : REGION_W'($urandom_range(0, 1023));
    h.hit_tag = TAG_W'($urandom_range(0, 65535));
    return h;
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    r.hit = '0;
    r.want = '0;
    hit_plan.push_back(r);
  endfunction

  function automatic void plan_hit(input row_kind_t kind, input logic [TIME_W-1:0] t,
                                   input logic [REGION_W-1:0] region,
                                   input logic [TAG_W-1:0] tag, input pair_t want);
    row_t r;
    r.kind = kind;
    r.idx = '0;
    r.data = '0;
    r.hit.hit_time = t;
    r.hit.hit_region = region;
    r.hit.hit_tag = tag;
    r.want = want;
    hit_plan.push_back(r);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("pair %0d %s: got %0h, want %0h", pairs_seen, name, got, want));
  endtask

  always @(posedge clk) begin : watch_pairs
    pair_t got;
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.first.hit_time = out_first_time;
      got.first.hit_region = out_first_region;
      got.first.hit_tag = out_first_tag;
      got.second.hit_time = out_second_time;
      got.second.hit_region = out_second_region;
      got.second.hit_tag = out_second_tag;
      got.last = out_last_pair;
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        report_mismatch($sformatf("pair %0d arrived with none expected", pairs_seen));
      end else begin
        want = pending_pairs.pop_front();
        check_field("first_time", got.first.hit_time, want.first.hit_time);
        check_field("first_region", TIME_W'(got.first.hit_region),
                    TIME_W'(want.first.hit_region));
        check_field("first_tag", TIME_W'(got.first.hit_tag), TIME_W'(want.first.hit_tag));
        check_field("second_time", got.second.hit_time, want.second.hit_time);
        check_field("second_region", TIME_W'(got.second.hit_region),
                    TIME_W'(want.second.hit_region));
        check_field("second_tag", TIME_W'(got.second.hit_tag),
                    TIME_W'(want.second.hit_tag));
        check_field("last_pair", TIME_W'(got.last), TIME_W'(want.last));
      end
    end
  end

  // Leaves cfg_valid high so that back-to-back writes follow without a gap; the
  // next hit request lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic send_hit(input hit_t h, input row_kind_t kind, input pair_t typed);
    int idle;
    idle = 0;
    while (idle < 24 && $urandom_range(0, 99) < send_idle_pct) idle++;
    cfg_valid <= 1'b0;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hit_time <= h.hit_time;
    in_hit_region <= h.hit_region;
    in_hit_tag <= h.hit_tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    find_coincidences(h);
    case (kind)
      ROW_HIT_NONE: ;
      ROW_HIT_ONE:  pending_pairs.push_back(typed);
      default:      foreach (fresh_pairs[i]) pending_pairs.push_back(fresh_pairs[i]);
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    bit                  after_hit;
    int                  p;
    int                  n;
    hit_t                h;
    logic [WINDOW_W-1:0] win;
    logic [TIME_W-1:0]   fs;
    logic [TIME_W-1:0]   fe;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_hit_time <= '0;
    in_hit_region <= '0;
    in_hit_tag <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WINDOW;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty ring, then pairs exactly at the reset window and one just past it.
    plan_hit(ROW_HIT_NONE, 48'd0, 10'd0, 16'h0000, '0);
    plan_hit(ROW_HIT_ONE, 48'd3000, 10'd1023, 16'hFFFF,
             {48'd3000, 10'd1023, 16'hFFFF, 48'd0, 10'd0, 16'h0000, 1'b1});
    // The stored hit of the same region is passed over.
    plan_hit(ROW_HIT_ONE, 48'd3001, 10'd0, 16'h1234,
             {48'd3000, 10'd1023, 16'hFFFF, 48'd3001, 10'd0, 16'h1234, 1'b1});
    plan_hit(ROW_HIT_NONE, 48'd6002, 10'd5, 16'h0005, '0);
    // Time steps backwards.
    plan_hit(ROW_HIT, 48'd6000, 10'd6, 16'h0006, '0);
    plan_cfg(REG_WINDOW, 48'd0);
    plan_hit(ROW_HIT_ONE, 48'd6000, 10'd7, 16'h0007,
             {48'd6000, 10'd7, 16'h0007, 48'd6000, 10'd6, 16'h0006, 1'b1});
    plan_cfg(REG_WINDOW, 48'hFF_FFFF_FFFF);
    plan_hit(ROW_HIT_NONE, TIME_TOP, 10'd1023, 16'hAAAA, '0);
    // A first time equal to the frame end is dropped.
    plan_hit(ROW_HIT_NONE, TIME_TOP, 10'd0, 16'h5555, '0);
    plan_cfg(REG_FRAME_START, 48'hFFFF_FFFF_FF00);
    plan_hit(ROW_HIT, 48'hFFFF_FFFF_FEFF, 10'd512, 16'h0F0F, '0);
    plan_hit(ROW_HIT, 48'hFFFF_FFFF_FF00, 10'd511, 16'hF0F0, '0);
    // Empty frames: start equal to end, then start above end.
    plan_cfg(REG_FRAME_START, 48'd6000);
    plan_cfg(REG_FRAME_END, 48'd6000);
    plan_cfg(REG_WINDOW, 48'd3000);
    plan_hit(ROW_HIT_NONE, 48'd6001, 10'd100, 16'h0064, '0);
    plan_cfg(REG_FRAME_START, TIME_TOP);
    plan_hit(ROW_HIT_NONE, 48'd6003, 10'd200, 16'h00C8, '0);
    // A write past the register list must leave the window alone.
    plan_cfg(REG_UNUSED, {CFG_DATA_W{1'b1}});
    plan_cfg(REG_FRAME_START, 48'd0);
    plan_cfg(REG_FRAME_END, TIME_TOP);
    plan_hit(ROW_HIT, 48'd6001, 10'd300, 16'hBEEF, '0);
    plan_hit(ROW_HIT, 48'd6001, 10'd300, 16'h0000, '0);

    after_hit = 1'b0;
    foreach (hit_plan[i]) begin
      if (hit_plan[i].kind == ROW_CFG) begin
        if (after_hit) wait_idle();
        write_reg(hit_plan[i].idx, hit_plan[i].data);
        after_hit = 1'b0;
      end else begin
        send_hit(hit_plan[i].hit, hit_plan[i].kind, hit_plan[i].want);
        after_hit = 1'b1;
      end
    end
    cur_time = 48'd6001;

    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (p)
        0: begin win = 24'd3000; fs = '0; fe = TIME_TOP; end
        1: begin
          win = 24'($urandom_range(1, 5000));
          fs = cur_time + TIME_W'($urandom_range(0, 2 * 32'(win)));
          fe = fs + TIME_W'($urandom_range(32'(win), 4 * 32'(win)));
        end
        2: begin win = '0; fs = '0; fe = TIME_TOP; end
        3: begin win = '1; fs = '0; fe = TIME_TOP; end
        4: begin
          win = 24'($urandom);
          fs = cur_time + TIME_W'($urandom_range(0, 32'(win)));
          fe = TIME_TOP;
        end
        default: begin
          win = 24'($urandom_range(100, 4000));
          fs = '0;
          fe = cur_time + TIME_W'($urandom_range(32'(win), 4 * 32'(win)));
        end
      endcase
      // Upper data bits beyond the window width must be dropped.
      write_reg(REG_WINDOW, {24'($urandom), win});
      write_reg(REG_FRAME_START, fs);
      write_reg(REG_FRAME_END, fe);
      for (n = 0; n < PHASE_HITS; n++) begin
        if (p == 1 && n == PHASE_HITS / 2) begin
          // Hold the next request back until the output has fully drained.
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_pairs.size() != 0);
        end
        h = next_hit();
        send_hit(h, ROW_HIT, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
